/* src/word_frequency_table_defines.svh */
// Assertion macros shared by the word frequency table RTL.
// Depends on the including module having aclk and aresetn in scope.
`ifndef WORD_FREQUENCY_TABLE_DEFINES_SVH
`define WORD_FREQUENCY_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define WFT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define WFT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define WFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wft_pkg.sv */
// Shared constants and controller/datapath interface types for the word frequency table.
// No dependencies.
package wft_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int WORD_BYTES    = 8;

    localparam int ADDR_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int IDX_W    = 10;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int LEN_W    = 4;
    localparam int POS_W    = 3;
    localparam int WORD_W   = 8 * WORD_BYTES;
    localparam int CMP_W    = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch the item, update the word assembly
        logic rd_en;      // issue a table read
        logic rd_search;  // read address comes from the search pointer
        logic ptr_clr;    // restart the search pointer
        logic hit_done;   // bump the matched count, load a word result
        logic miss_done;  // insert or drop, load a word result
        logic read_done;  // load a read reply
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_read;    // mode of the item on the input port
        logic word_done;  // input item completes a nonempty word
        logic match_now;  // table data register holds a matching entry
        logic ptr_end;    // every entry in use has been read
        logic data_valid; // table data register holds a search read
        logic out_free;   // output register may be loaded this cycle
    } status_t;

endpackage

/* src/word_frequency_table.sv */
// Word frequency table: counts occurrences of each distinct word.
// Input channel (s_*): one item per byte (mode 0) or one read request (mode 1).
//   A mode 0 item with s_end_of_word closes the word; bytes past the stored
//   word length are dropped and the result is flagged as truncated.
// Result channel (m_*): one item per completed nonempty word and per read request.
// Timing:
//   - A byte that does not end a word leaves the controller idle, so bytes
//     stream at one per cycle.
//   - A word end walks the stored entries with one memory read per cycle,
//     stopping at the first matching entry (a hit) or after the last entry
//     in use (a miss); a miss inserts the word if the table has room.
//   - A read request reads the table, then loads its reply once the output is free.
//   - No new item is taken while a search or read is in progress.
// Reset clears the assembly and the count of entries in use; the table
// memories are not cleared; entries at or above the count in use are never returned.
// When the receiver stalls, the result waits in the output register; byte
// items keep flowing, and a finished search waits for the register to free.
// Depends on wft_pkg, wft_ctrl and wft_dp.
module word_frequency_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [wft_pkg::CHAR_W-1:0]    s_char_byte,
    input  logic                          s_end_of_word,
    input  logic [wft_pkg::IDX_W-1:0]     s_entry_index,
    input  logic [wft_pkg::POS_W-1:0]     s_char_pos,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_is_read_reply,
    output logic [wft_pkg::IDX_W-1:0]     m_result_index,
    output logic [wft_pkg::COUNT_W-1:0]   m_word_count,
    output logic                          m_is_new,
    output logic                          m_dropped_full,
    output logic                          m_was_truncated,
    output logic                          m_entry_valid,
    output logic [wft_pkg::CHAR_W-1:0]    m_char_out,
    output logic [wft_pkg::LEN_W-1:0]     m_word_length
);

    wft_pkg::cmd_t    cmd;
    wft_pkg::status_t status;

    wft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wft_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_mode          (s_mode),
        .s_char_byte     (s_char_byte),
        .s_end_of_word   (s_end_of_word),
        .s_entry_index   (s_entry_index),
        .s_char_pos      (s_char_pos),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_read_reply (m_is_read_reply),
        .m_result_index  (m_result_index),
        .m_word_count    (m_word_count),
        .m_is_new        (m_is_new),
        .m_dropped_full  (m_dropped_full),
        .m_was_truncated (m_was_truncated),
        .m_entry_valid   (m_entry_valid),
        .m_char_out      (m_char_out),
        .m_word_length   (m_word_length)
    );

endmodule

/* src/wft_ctrl.sv */
// Sequencer for the word frequency table: accepts items, walks the search, loads results.
// Depends on wft_pkg.
module wft_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wft_pkg::status_t    status,
    output wft_pkg::cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_RD_ISSUE = 6'b000010,
        ST_RD_WAIT  = 6'b000100,
        ST_SEARCH   = 6'b001000,
        ST_HIT      = 6'b010000,
        ST_MISS     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.is_read) begin
                        state_next = ST_RD_ISSUE;
                    end else if (status.word_done) begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = ST_SEARCH;
                    end
                end
            end
            ST_RD_ISSUE: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                if (status.out_free) begin
                    cmd.read_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                // one read in flight; stop issuing as soon as a match shows
                if (status.match_now) begin
                    state_next = ST_HIT;
                end else if (status.ptr_end) begin
                    if (!status.data_valid) begin
                        state_next = ST_MISS;
                    end
                end else begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_search = 1'b1;
                end
            end
            ST_HIT: begin
                if (status.out_free) begin
                    cmd.hit_done = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (status.out_free) begin
                    cmd.miss_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/wft_dp.sv */
// Datapath of the word frequency table: word assembly, word and count memories,
// search pointer and result register. Depends on wft_pkg and the defines header.
`include "word_frequency_table_defines.svh"

module wft_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_mode,
    input  logic [wft_pkg::CHAR_W-1:0]       s_char_byte,
    input  logic                             s_end_of_word,
    input  logic [wft_pkg::IDX_W-1:0]        s_entry_index,
    input  logic [wft_pkg::POS_W-1:0]        s_char_pos,
    input  wft_pkg::cmd_t                    cmd,
    output wft_pkg::status_t                 status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_is_read_reply,
    output logic [wft_pkg::IDX_W-1:0]        m_result_index,
    output logic [wft_pkg::COUNT_W-1:0]      m_word_count,
    output logic                             m_is_new,
    output logic                             m_dropped_full,
    output logic                             m_was_truncated,
    output logic                             m_entry_valid,
    output logic [wft_pkg::CHAR_W-1:0]       m_char_out,
    output logic [wft_pkg::LEN_W-1:0]        m_word_length
);

    localparam int MEM_W = wft_pkg::WORD_W + wft_pkg::LEN_W;

    // word assembly
    logic [wft_pkg::WORD_W-1:0]  asm_bytes_reg, asm_bytes_next, add_bytes;
    logic [wft_pkg::LEN_W-1:0]   asm_len_reg, asm_len_next, add_len;
    logic                        ovf_reg, ovf_next, add_ovf;

    // latched read request
    logic [wft_pkg::IDX_W-1:0]   idx_reg;
    logic [wft_pkg::POS_W-1:0]   pos_reg;

    // table
    logic [MEM_W-1:0]            word_mem [wft_pkg::TABLE_ENTRIES];
    logic [wft_pkg::COUNT_W-1:0] cnt_mem  [wft_pkg::TABLE_ENTRIES];
    logic [MEM_W-1:0]            word_q;
    logic [wft_pkg::COUNT_W-1:0] cnt_q;
    logic [wft_pkg::ADDR_W-1:0]  rd_addr;
    logic [wft_pkg::ADDR_W-1:0]  eu_addr;
    logic [wft_pkg::CNT_W-1:0]   entries_used_reg;
    logic                        room;

    // search
    logic [wft_pkg::CNT_W-1:0]   ptr_reg;
    logic [wft_pkg::ADDR_W-1:0]  dptr_reg;
    logic                        dvalid_reg;
    logic [wft_pkg::COUNT_W-1:0] cnt_inc;

    // read reply pieces
    logic                        rd_in_use;
    logic [wft_pkg::CHAR_W-1:0]  rd_char;

    // result register
    logic                        m_valid_reg;
    logic                        is_read_reply_reg;
    logic [wft_pkg::IDX_W-1:0]   result_index_reg;
    logic [wft_pkg::COUNT_W-1:0] word_count_reg;
    logic                        is_new_reg;
    logic                        dropped_full_reg;
    logic                        was_truncated_reg;
    logic                        entry_valid_reg;
    logic [wft_pkg::CHAR_W-1:0]  char_out_reg;
    logic [wft_pkg::LEN_W-1:0]   word_length_reg;

    // ---------------- word assembly ----------------
    always_comb begin
        add_bytes = asm_bytes_reg;
        add_len   = asm_len_reg;
        add_ovf   = ovf_reg;
        if (s_char_byte != '0) begin
            if (asm_len_reg < wft_pkg::LEN_W'(wft_pkg::WORD_BYTES)) begin
                for (int k = 0; k < wft_pkg::WORD_BYTES; k++) begin
                    if (asm_len_reg == wft_pkg::LEN_W'(k)) begin
                        add_bytes[8*k +: 8] = s_char_byte;
                    end
                end
                add_len = asm_len_reg + wft_pkg::LEN_W'(1);
            end else begin
                add_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        asm_bytes_next = asm_bytes_reg;
        asm_len_next   = asm_len_reg;
        ovf_next       = ovf_reg;
        if (cmd.accept && !s_mode) begin
            if (s_end_of_word && add_len == '0) begin
                // empty word: nothing to look up
                asm_bytes_next = '0;
                asm_len_next   = '0;
                ovf_next       = 1'b0;
            end else begin
                asm_bytes_next = add_bytes;
                asm_len_next   = add_len;
                ovf_next       = add_ovf;
            end
        end else if (cmd.hit_done || cmd.miss_done) begin
            asm_bytes_next = '0;
            asm_len_next   = '0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asm_bytes_reg <= '0;
            asm_len_reg   <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            asm_bytes_reg <= asm_bytes_next;
            asm_len_reg   <= asm_len_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg <= s_entry_index;
            pos_reg <= s_char_pos;
        end
    end

    // ---------------- table memories ----------------
    assign rd_addr = cmd.rd_search ? ptr_reg[wft_pkg::ADDR_W-1:0]
                                   : wft_pkg::ADDR_W'(idx_reg);
    assign eu_addr = entries_used_reg[wft_pkg::ADDR_W-1:0];
    assign room    = entries_used_reg < wft_pkg::CNT_W'(wft_pkg::TABLE_ENTRIES);
    assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + wft_pkg::COUNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            word_q <= word_mem[rd_addr];
        end
        if (cmd.miss_done && room) begin
            word_mem[eu_addr] <= {asm_len_reg, asm_bytes_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            cnt_q <= cnt_mem[rd_addr];
        end
        if (cmd.hit_done) begin
            cnt_mem[dptr_reg] <= cnt_inc;
        end else if (cmd.miss_done && room) begin
            cnt_mem[eu_addr] <= wft_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_used_reg <= '0;
        end else if (cmd.miss_done && room) begin
            entries_used_reg <= entries_used_reg + wft_pkg::CNT_W'(1);
        end
    end

    // ---------------- search pointer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            dvalid_reg <= 1'b0;
        end else begin
            dvalid_reg <= cmd.rd_en && cmd.rd_search;
            if (cmd.ptr_clr) begin
                ptr_reg <= '0;
            end else if (cmd.rd_en && cmd.rd_search) begin
                ptr_reg <= ptr_reg + wft_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en && cmd.rd_search) begin
            dptr_reg <= rd_addr;
        end
    end

    // ---------------- read reply ----------------
    assign rd_in_use = wft_pkg::CMP_W'(idx_reg) < wft_pkg::CMP_W'(entries_used_reg);

    always_comb begin
        rd_char = '0;
        for (int k = 0; k < wft_pkg::WORD_BYTES; k++) begin
            if (pos_reg == wft_pkg::POS_W'(k)) begin
                rd_char = word_q[8*k +: 8];
            end
        end
    end

    // ---------------- result register ----------------
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.hit_done || cmd.miss_done || cmd.read_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_done) begin
            is_read_reply_reg <= 1'b1;
            result_index_reg  <= idx_reg;
            is_new_reg        <= 1'b0;
            dropped_full_reg  <= 1'b0;
            was_truncated_reg <= 1'b0;
            entry_valid_reg   <= rd_in_use;
            word_count_reg    <= rd_in_use ? cnt_q : '0;
            char_out_reg      <= rd_in_use ? rd_char : '0;
            word_length_reg   <= rd_in_use ? word_q[MEM_W-1 -: wft_pkg::LEN_W] : '0;
        end else if (cmd.hit_done) begin
            is_read_reply_reg <= 1'b0;
            result_index_reg  <= wft_pkg::IDX_W'(dptr_reg);
            word_count_reg    <= cnt_inc;
            is_new_reg        <= 1'b0;
            dropped_full_reg  <= 1'b0;
            was_truncated_reg <= ovf_reg;
            entry_valid_reg   <= 1'b0;
            char_out_reg      <= '0;
            word_length_reg   <= asm_len_reg;
        end else if (cmd.miss_done) begin
            is_read_reply_reg <= 1'b0;
            result_index_reg  <= room ? wft_pkg::IDX_W'(eu_addr) : '0;
            word_count_reg    <= room ? wft_pkg::COUNT_W'(1) : '0;
            is_new_reg        <= room;
            dropped_full_reg  <= !room;
            was_truncated_reg <= ovf_reg;
            entry_valid_reg   <= 1'b0;
            char_out_reg      <= '0;
            word_length_reg   <= asm_len_reg;
        end
    end

    // ---------------- status ----------------
    assign status.is_read    = s_mode;
    assign status.word_done  = !s_mode && s_end_of_word && (add_len != '0);
    assign status.match_now  = dvalid_reg
                               && (word_q[wft_pkg::WORD_W-1:0] == asm_bytes_reg);
    assign status.ptr_end    = ptr_reg == entries_used_reg;
    assign status.data_valid = dvalid_reg;

    assign m_valid         = m_valid_reg;
    assign m_is_read_reply = is_read_reply_reg;
    assign m_result_index  = result_index_reg;
    assign m_word_count    = word_count_reg;
    assign m_is_new        = is_new_reg;
    assign m_dropped_full  = dropped_full_reg;
    assign m_was_truncated = was_truncated_reg;
    assign m_entry_valid   = entry_valid_reg;
    assign m_char_out      = char_out_reg;
    assign m_word_length   = word_length_reg;

    // ---------------- checks ----------------
    `WFT_ASSERT_ALWAYS(a_used_bound, entries_used_reg <= wft_pkg::CNT_W'(wft_pkg::TABLE_ENTRIES), "entries in use exceed table size")
    `WFT_ASSERT_ALWAYS(a_len_bound, asm_len_reg <= wft_pkg::LEN_W'(wft_pkg::WORD_BYTES), "assembly length exceeds word size")
    `WFT_ASSERT_SAME(a_no_overwrite, cmd.hit_done || cmd.miss_done || cmd.read_done, !m_valid_reg || m_ready, "result register loaded while still held")
    `WFT_ASSERT_NEXT(a_search_bound, dvalid_reg, ptr_reg <= entries_used_reg, "search pointer ran past entries in use")

endmodule
